// ----- rtl/core/nsr_pkg.sv -----
// ----------------------------------------------------------------------------
// nsr_pkg
// Types and constants shared by the Newton-Raphson square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Fraction bits of the Q16.16 format.
  localparam int FRAC_BITS = 16;

  // Widths of the ports and configuration registers.
  localparam int RADICAND_W  = 32;
  localparam int ROOT_W      = 32;
  localparam int GUESS_W     = 32;
  localparam int TOL_W       = 16;
  localparam int LIMIT_W     = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Reset values of the configuration registers.
  localparam logic [GUESS_W-1:0] GUESS_RESET = 32'd327680;  // 5.0
  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } nsr_state_t;

endpackage

// ----- rtl/core/newton_square_root.sv -----
// ----------------------------------------------------------------------------
// newton_square_root
// Square root of an unsigned Q16.16 value by Newton-Raphson iteration.
//
// Usage: write the configuration registers (initial guess, tolerance,
// iteration limit) through cfg_we / cfg_index / cfg_wdata while the block
// is idle. A radicand is transferred at a clock edge where start is high and
// busy is low. The block then repeats x_next = (x + a/x) / 2, where each
// quotient comes from one shared restoring divider that produces one bit per
// cycle. With a 32-bit value path a Newton step computes 48 quotient bits
// and then applies the update. busy stays high while the block iterates.
// The result appears on out_root, out_steps_taken and out_converged for
// exactly one cycle while out_valid is high; the receiver cannot stall, so
// the result must be taken in that cycle. busy falls in the same cycle.
// Reset returns the block to idle and restores the register defaults.
// ----------------------------------------------------------------------------
module newton_square_root
  import nsr_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [RADICAND_W-1:0] in_radicand,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [LIMIT_W-1:0]    out_steps_taken,
  output logic                  out_converged,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int W     = VALUE_WIDTH;
  localparam int AW    = (W < RADICAND_W) ? W : RADICAND_W;
  localparam int DW    = AW + FRAC_BITS;
  localparam int CW    = (DW > W) ? DW : W;
  localparam int CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

  nsr_state_t           state_r, state_nxt;

  logic [GUESS_W-1:0]   guess_r;
  logic [TOL_W-1:0]     tol_r;
  logic [LIMIT_W-1:0]   limit_r;

  logic [AW-1:0]        a_r, a_nxt;
  logic [W-1:0]         x_r, x_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]        dsh_r, dsh_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0]   steps_r, steps_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]    out_root_r, out_root_nxt;
  logic [LIMIT_W-1:0]   out_steps_r, out_steps_nxt;
  logic                 out_conv_r, out_conv_nxt;

  logic                 accept;
  logic [W-1:0]         guess_w;
  logic [W:0]           rem_sh;
  logic                 rem_ge;
  logic [CW-1:0]        q_ext;
  logic                 q_sat;
  logic [W-1:0]         q_w;
  logic [W:0]           sum_w;
  logic [W-1:0]         next_w;
  logic [W-1:0]         diff_w;
  logic                 conv;
  logic [LIMIT_W-1:0]   steps_inc;
  logic [LIMIT_W-1:0]   limit_eff;
  logic                 last_step;

  assign accept = start && (state_r == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guess_r <= GUESS_RESET;
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_GUESS:   guess_r <= cfg_wdata[GUESS_W-1:0];
        CFG_TOLERANCE:       tol_r   <= cfg_wdata[TOL_W-1:0];
        CFG_ITERATION_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider step: one quotient bit of floor(a * 2^16 / x) per cycle.
  always_comb begin
    rem_sh = {rem_r, dsh_r[DW-1]};
    rem_ge = (rem_sh >= {1'b0, x_r});
  end

  // Newton update from the finished quotient.
  always_comb begin
    guess_w = W'(guess_r);
    if (guess_w == '0) begin
      guess_w = W'(1);
    end
    q_ext = CW'(quo_r);
    q_sat = (q_ext > CW'({W{1'b1}}));
    q_w   = q_sat ? {W{1'b1}} : W'(quo_r);
    sum_w = {1'b0, x_r >> 1} + {1'b0, q_w >> 1} + (W+1)'(x_r[0] & q_w[0]);
    next_w = sum_w[W-1:0];
    if (next_w == '0) begin
      next_w = W'(1);
    end
    diff_w    = (next_w >= x_r) ? (next_w - x_r) : (x_r - next_w);
    conv      = (diff_w < W'(tol_r));
    steps_inc = steps_r + LIMIT_W'(1);
    limit_eff = (limit_r == '0) ? LIMIT_W'(1) : limit_r;
    last_step = conv || (steps_inc >= limit_eff);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = last_step ? ST_IDLE : ST_DIV;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    a_nxt         = a_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dsh_nxt       = dsh_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_root_nxt  = out_root_r;
    out_steps_nxt = out_steps_r;
    out_conv_nxt  = out_conv_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_nxt     = in_radicand[AW-1:0];
          x_nxt     = guess_w;
          rem_nxt   = '0;
          quo_nxt   = '0;
          dsh_nxt   = {in_radicand[AW-1:0], {FRAC_BITS{1'b0}}};
          cnt_nxt   = '0;
          steps_nxt = '0;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? W'(rem_sh - {1'b0, x_r}) : rem_sh[W-1:0];
        quo_nxt = {quo_r[DW-2:0], rem_ge};
        dsh_nxt = dsh_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_UPDATE: begin
        steps_nxt = steps_inc;
        if (last_step) begin
          // The reported root is the estimate held before this update.
          out_valid_nxt = 1'b1;
          out_root_nxt  = ROOT_W'(x_r);
          out_steps_nxt = steps_inc;
          out_conv_nxt  = conv;
        end else begin
          x_nxt   = next_w;
          rem_nxt = '0;
          quo_nxt = '0;
          dsh_nxt = {a_r, {FRAC_BITS{1'b0}}};
          cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    x_r         <= x_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dsh_r       <= dsh_nxt;
    out_root_r  <= out_root_nxt;
    out_steps_r <= out_steps_nxt;
    out_conv_r  <= out_conv_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_root        = out_root_r;
  assign out_steps_taken = out_steps_r;
  assign out_converged   = out_conv_r;

endmodule

// ----- sim/tb_newton_square_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_square_root
// Self-checking bench for the Newton-Raphson square root block. Radicands
// are sent through the start/busy command port, first a directed set under
// the reset and extreme register values, then random phases, the first with
// the reset values and the rest with random register settings. Every
// transfer is predicted from a local copy of the registers, and every
// out_valid strobe is compared with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module tb_newton_square_root;
  import nsr_pkg::*;

  localparam int              CLK_HALF     = 6;
  localparam longint unsigned CYCLE_LIMIT  = 40_000_000;
  localparam int              RANDOM_ITEMS = 1780;
  localparam int              PHASES       = 8;

  typedef struct packed {
    logic [ROOT_W-1:0]  root;
    logic [LIMIT_W-1:0] steps;
    logic               converged;
  } root_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic [RADICAND_W-1:0] in_radicand = '0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_INITIAL_GUESS;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  busy;
  logic                  out_valid;
  logic [ROOT_W-1:0]     out_root;
  logic [LIMIT_W-1:0]    out_steps_taken;
  logic                  out_converged;

  // Local copies of the configuration registers.
  logic [GUESS_W-1:0] guess_reg = GUESS_RESET;
  logic [TOL_W-1:0]   tol_reg   = TOL_RESET;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

  root_result_t    pending_roots[$];
  int unsigned     mismatch_count = 0;
  int unsigned     result_count   = 0;
  longint unsigned cycle_count    = 0;
  bit              sender_idles   = 1'b1;

  newton_square_root #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_radicand    (in_radicand),
    .out_valid      (out_valid),
    .out_root       (out_root),
    .out_steps_taken(out_steps_taken),
    .out_converged  (out_converged),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Runs the iteration on 64-bit values so that the Q16.16 quotient of a
  // 32-bit radicand is exact before it saturates to 32 bits.
  function automatic root_result_t newton_root_of(input logic [RADICAND_W-1:0] a);
    logic [63:0]  est;
    logic [63:0]  prev;
    logic [63:0]  quot;
    logic [63:0]  diff;
    int unsigned  limit;
    int unsigned  n;
    bit           done;
    root_result_t res;
    est   = (guess_reg == '0) ? 64'd1 : 64'(guess_reg);
    limit = (limit_reg == '0) ? 1 : int'(limit_reg);
    prev  = '0;
    n     = 0;
    done  = 1'b0;
    while (!done && n < limit) begin
      prev = est;
      quot = {16'd0, a, 16'd0} / prev;
      if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
      est = (prev + quot) >> 1;
      if (est == 64'd0) est = 64'd1;
      n++;
      diff = (est >= prev) ? est - prev : prev - est;
      done = (diff < 64'(tol_reg));
    end
    res.root      = prev[ROOT_W-1:0];
    res.steps     = LIMIT_W'(n);
    res.converged = done;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    root_result_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        report_mismatch("out_valid is unknown");
      end else if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result, root %h", out_root));
      end else begin
        want = pending_roots.pop_front();
        if (out_root !== want.root)
          report_mismatch($sformatf("result %0d: root %h, expected %h",
                                    result_count, out_root, want.root));
        if (out_steps_taken !== want.steps)
          report_mismatch($sformatf("result %0d: steps_taken %0d, expected %0d",
                                    result_count, out_steps_taken, want.steps));
        if (out_converged !== want.converged)
          report_mismatch($sformatf("result %0d: converged %b, expected %b",
                                    result_count, out_converged, want.converged));
      end
      result_count++;
    end
  end

  // Leaves start high after the transfer so that a following call can keep
  // it high; every caller either sends again or drains in the same step.
  task automatic send_radicand(input logic [RADICAND_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if (sender_idles) begin
      if ($urandom_range(99) < 4) gap = $urandom_range(1, 150);
      else while ($urandom_range(99) < 18) gap++;
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_radicand <= value;
    do @(posedge clk); while (busy !== 1'b0);
    pending_roots.push_back(newton_root_of(value));
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive cycles; only called while idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] guess,
                              input logic [CFG_DATA_W-1:0] tol_word,
                              input logic [CFG_DATA_W-1:0] limit_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INITIAL_GUESS;
    cfg_wdata <= guess;
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= tol_word;
    @(posedge clk);
    cfg_index <= CFG_ITERATION_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    guess_reg = guess;
    tol_reg   = tol_word[TOL_W-1:0];
    limit_reg = limit_word[LIMIT_W-1:0];
  endtask

  task automatic test_default_config();
    logic [RADICAND_W-1:0] values[] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0001_0000, 32'h0004_0000,
      32'h0019_0000, 32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };
    foreach (values[i]) send_radicand(values[i]);
    wait_all_results();
  endtask

  task automatic test_register_extremes();
    // Zero guess and zero limit both act as one; zero tolerance is never met.
    write_config(32'd0, 32'd0, 32'd0);
    send_radicand(32'h0000_0000);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0001_0000);
    wait_all_results();
    write_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'd63);
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0019_0000);
    wait_all_results();
    // A one-LSB guess saturates the first quotient; a zero radicand drives
    // the estimate to zero, where it is held at one.
    write_config(32'd1, 32'd0, 32'd63);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0000_0000);
    wait_all_results();
  endtask

  task automatic test_random_phases();
    logic [GUESS_W-1:0]    guess;
    logic [TOL_W-1:0]      tol;
    logic [LIMIT_W-1:0]    limit;
    logic [RADICAND_W-1:0] value;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        guess = GUESS_RESET;
        tol   = TOL_RESET;
        limit = LIMIT_RESET;
      end else begin
        case ($urandom_range(7))
          0:       guess = '0;
          1:       guess = '1;
          2, 3:    guess = $urandom;
          default: guess = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(5))
          0:       tol = '0;
          1:       tol = 16'd1;
          2:       tol = TOL_W'($urandom_range(2, 16));
          3:       tol = TOL_W'($urandom_range(0, 65535));
          default: tol = TOL_W'($urandom_range(1, 4));
        endcase
        // Without a tolerance every item runs to the limit, so keep it short.
        if (tol == '0) limit = LIMIT_W'($urandom_range(0, 10));
        else case ($urandom_range(5))
          0:       limit = LIMIT_W'($urandom_range(0, 11));
          1:       limit = LIMIT_W'($urandom_range(41, 63));
          default: limit = LIMIT_W'($urandom_range(12, 40));
        endcase
      end
      write_config(guess, {16'($urandom), tol}, {26'($urandom), limit});
      // One phase runs with the sender never idling.
      sender_idles = (phase != 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        case ($urandom_range(3))
          0:       value = $urandom;
          1:       value = $urandom >> $urandom_range(0, 31);
          2:       value = RADICAND_W'($urandom_range(0, 255)) << FRAC_BITS;
          default: value = $urandom_range(0, 15);
        endcase
        if ($urandom_range(99) == 0) wait_all_results();
        send_radicand(value);
      end
      wait_all_results();
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_register_extremes();
    test_random_phases();
    wait_all_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/nsr_pkg.sv
rtl/core/newton_square_root.sv
sim/tb_newton_square_root.sv
